### src/calu_pkg.sv
// Shared operation codes, flag positions and pipeline stage types for the ALU.
package calu_pkg;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_ADC    = 4'd1;
    localparam logic [3:0] OP_SUB    = 4'd2;
    localparam logic [3:0] OP_SBC    = 4'd3;
    localparam logic [3:0] OP_AND    = 4'd4;
    localparam logic [3:0] OP_XOR    = 4'd5;
    localparam logic [3:0] OP_OR     = 4'd6;
    localparam logic [3:0] OP_ADD_HL = 4'd7;
    localparam logic [3:0] OP_ADD_SP = 4'd8;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0] SIGN_MASK = 8'h80;

    typedef struct packed {
        logic       valid;
        logic       advance;
    } pipe_ctl_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [15:0] word_base;
        logic [7:0]  word_hi;
        logic [3:0]  flags;
        logic [7:0]  lo_sum;
        logic        h_lo;
        logic        c_lo;
    } s1_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [15:0] word_base;
        logic [3:0]  flags;
        logic [7:0]  lo_sum;
        logic        h_lo;
        logic        c_lo;
        logic [7:0]  hi_sum;
        logic        h_hi;
        logic        c_hi;
    } s2_t;

endpackage

### src/calu_stage1.sv
// Stage 1: operand selection and the low-byte adder with nibble carry.
module calu_stage1 (
    input  logic               clk,
    input  logic               rst_n,
    input  calu_pkg::pipe_ctl_t ctl,
    input  logic [3:0]         operation,
    input  logic [7:0]         acc,
    input  logic [7:0]         operand,
    input  logic [15:0]        word_base,
    input  logic [15:0]        operand_word,
    input  logic [3:0]         flags_in,
    output logic               valid_reg,
    output calu_pkg::s1_t      data_reg
);
    import calu_pkg::*;

    logic       is_sub;
    logic       carry_sel;
    logic [7:0] x;
    logic [7:0] y;
    logic       ci;
    logic [4:0] nib;
    logic [4:0] hi;
    s1_t        data_next;

    always_comb
    begin
        is_sub    = (operation == OP_SUB) || (operation == OP_SBC);
        carry_sel = flags_in[FLAG_C] && ((operation == OP_ADC) || (operation == OP_SBC));
        x  = acc;
        y  = operand;
        ci = 1'b0;
        case (operation)
            OP_ADD, OP_ADC:
            begin
                y  = operand;
                ci = carry_sel;
            end
            // a - b - c computed as a + ~b + !c; borrow is the inverted carry
            OP_SUB, OP_SBC:
            begin
                y  = ~operand;
                ci = ~carry_sel;
            end
            OP_ADD_HL:
            begin
                x = word_base[7:0];
                y = operand_word[7:0];
            end
            OP_ADD_SP:
            begin
                x = word_base[7:0];
                y = operand;
            end
            default:
            begin
                x  = acc;
                y  = operand;
                ci = 1'b0;
            end
        endcase
        nib = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'd0, ci};
        hi  = {1'b0, x[7:4]} + {1'b0, y[7:4]} + {4'd0, nib[4]};

        data_next.op        = operation;
        data_next.acc       = acc;
        data_next.operand   = operand;
        data_next.word_base = word_base;
        data_next.word_hi   = operand_word[15:8];
        data_next.flags     = flags_in;
        data_next.lo_sum    = {hi[3:0], nib[3:0]};
        data_next.h_lo      = nib[4] & ~is_sub | nib[4] & is_sub;
        data_next.c_lo      = hi[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && ctl.valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### src/calu_stage2.sv
// Stage 2: high-byte adder for the 16-bit word operations.
module calu_stage2 (
    input  logic               clk,
    input  logic               rst_n,
    input  calu_pkg::pipe_ctl_t ctl,
    input  calu_pkg::s1_t      data_in,
    output logic               valid_reg,
    output calu_pkg::s2_t      data_reg
);
    import calu_pkg::*;

    logic [7:0] y;
    logic [4:0] nib;
    logic [4:0] hi;
    s2_t        data_next;

    always_comb
    begin
        // SP add sign-extends the offset byte into the high byte
        if (data_in.op == OP_ADD_HL)
        begin
            y = data_in.word_hi;
        end
        else
        begin
            y = ((data_in.operand & SIGN_MASK) != 8'h00) ? 8'hFF : 8'h00;
        end
        nib = {1'b0, data_in.word_base[11:8]} + {1'b0, y[3:0]} + {4'd0, data_in.c_lo};
        hi  = {1'b0, data_in.word_base[15:12]} + {1'b0, y[7:4]} + {4'd0, nib[4]};

        data_next.op        = data_in.op;
        data_next.acc       = data_in.acc;
        data_next.operand   = data_in.operand;
        data_next.word_base = data_in.word_base;
        data_next.flags     = data_in.flags;
        data_next.lo_sum    = data_in.lo_sum;
        data_next.h_lo      = data_in.h_lo;
        data_next.c_lo      = data_in.c_lo;
        data_next.hi_sum    = {hi[3:0], nib[3:0]};
        data_next.h_hi      = nib[4];
        data_next.c_hi      = hi[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && ctl.valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### src/calu_stage3.sv
// Stage 3: logic operations, result selection, flag generation and output register.
module calu_stage3 (
    input  logic               clk,
    input  logic               rst_n,
    input  calu_pkg::pipe_ctl_t ctl,
    input  calu_pkg::s2_t      data_in,
    output logic               valid_reg,
    output logic [7:0]         acc_reg,
    output logic [15:0]        word_reg,
    output logic [3:0]         flags_reg
);
    import calu_pkg::*;

    logic [7:0]  acc_next;
    logic [15:0] word_next;
    logic [3:0]  flags_next;

    always_comb
    begin
        acc_next   = data_in.acc;
        word_next  = data_in.word_base;
        flags_next = data_in.flags;
        case (data_in.op)
            OP_ADD, OP_ADC:
            begin
                acc_next   = data_in.lo_sum;
                flags_next = {data_in.lo_sum == 8'h00, 1'b0, data_in.h_lo, data_in.c_lo};
            end
            OP_SUB, OP_SBC:
            begin
                acc_next   = data_in.lo_sum;
                flags_next = {data_in.lo_sum == 8'h00, 1'b1, ~data_in.h_lo, ~data_in.c_lo};
            end
            OP_AND:
            begin
                acc_next   = data_in.acc & data_in.operand;
                flags_next = {acc_next == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR:
            begin
                acc_next   = data_in.acc ^ data_in.operand;
                flags_next = {acc_next == 8'h00, 3'b000};
            end
            OP_OR:
            begin
                acc_next   = data_in.acc | data_in.operand;
                flags_next = {acc_next == 8'h00, 3'b000};
            end
            OP_ADD_HL:
            begin
                word_next  = {data_in.hi_sum, data_in.lo_sum};
                flags_next = {data_in.flags[FLAG_Z], 1'b0, data_in.h_hi, data_in.c_hi};
            end
            // SP add flags come from the unsigned low-byte sum
            OP_ADD_SP:
            begin
                word_next  = {data_in.hi_sum, data_in.lo_sum};
                flags_next = {2'b00, data_in.h_lo, data_in.c_lo};
            end
            default:
            begin
                acc_next   = data_in.acc;
                word_next  = data_in.word_base;
                flags_next = data_in.flags;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && ctl.valid)
        begin
            acc_reg   <= acc_next;
            word_reg  <= word_next;
            flags_reg <= flags_next;
        end
    end

endmodule

### src/cpu_alu_with_flags_core.sv
// Top level of the pipelined 8-bit ALU with Z N H C flags.
// Three register stages: low-byte add, high-byte add, then result select with the
// output register. An input transfer is registered in stage 1, then stage 2, then the
// output register, where out_valid rises; one item is accepted every cycle while the
// output is taken. A stalled output holds only the stages behind it that are full, so
// bubbles keep filling and in_stall rises only when all three stages hold items.
module cpu_alu_with_flags_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  operation,
    input  logic [7:0]  acc,
    input  logic [7:0]  operand,
    input  logic [15:0] word_base,
    input  logic [15:0] operand_word,
    input  logic [3:0]  flags_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  acc_out,
    output logic [15:0] word_out,
    output logic [3:0]  flags_out
);
    import calu_pkg::*;

    pipe_ctl_t ctl1;
    pipe_ctl_t ctl2;
    pipe_ctl_t ctl3;
    logic      v1;
    logic      v2;
    s1_t       d1;
    s2_t       d2;

    always_comb
    begin
        ctl3.advance = !out_valid || !out_stall;
        ctl2.advance = !v2 || ctl3.advance;
        ctl1.advance = !v1 || ctl2.advance;
        ctl1.valid   = in_valid;
        ctl2.valid   = v1;
        ctl3.valid   = v2;
    end

    assign in_stall = !ctl1.advance;

    calu_stage1 u_stage1 (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl1),
        .operation    (operation),
        .acc          (acc),
        .operand      (operand),
        .word_base    (word_base),
        .operand_word (operand_word),
        .flags_in     (flags_in),
        .valid_reg    (v1),
        .data_reg     (d1)
    );

    calu_stage2 u_stage2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl2),
        .data_in   (d1),
        .valid_reg (v2),
        .data_reg  (d2)
    );

    calu_stage3 u_stage3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl3),
        .data_in   (d2),
        .valid_reg (out_valid),
        .acc_reg   (acc_out),
        .word_reg  (word_out),
        .flags_reg (flags_out)
    );

endmodule

### src/calu_checker.sv
// Port-level assertions for the ALU pipeline and the bind that attaches them.
module calu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [3:0]  operation,
    input logic [7:0]  acc,
    input logic [7:0]  operand,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  acc_out,
    input logic [3:0]  flags_out
);
    import calu_pkg::*;

    // a waiting result is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // an open output never backs up the input
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("in_stall high while output is open");

    // a free-flowing transfer, with the output open behind it, reaches out_valid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("result missing after three cycles");

    // AND result and H, N, C flags through a free-flowing pipeline
    a_and_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == OP_AND ##1 !out_stall ##1 !out_stall
        |=> acc_out == ($past(acc, 3) & $past(operand, 3))
            && flags_out[FLAG_H] && !flags_out[FLAG_N] && !flags_out[FLAG_C])
        else $error("AND result mismatch");

endmodule

bind cpu_alu_with_flags_core calu_checker u_calu_checker (.*);
